### rtl/core/lfh_pkg.sv
// lfh_pkg: shared types and constants of the led fire heat grid renderer
// no dependencies; imported by lfh_dp, lfh_ctrl and the top level
`default_nettype none

package lfh_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  column;
    logic [2:0]  heat_row;
    logic [31:0] random_word;
    logic [7:0]  blend_phase;
  } lfh_in_t;

  typedef struct packed {
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } lfh_out_t;

  typedef struct packed {
    logic [7:0] spark_low;
    logic [7:0] spark_high;
    logic [7:0] cooling_gain;
    logic [7:0] bottom_hue;
  } lfh_cfg_t;

  // item modes
  localparam logic [1:0] MODE_SPARK  = 2'd0;
  localparam logic [1:0] MODE_SHIFT  = 2'd1;
  localparam logic [1:0] MODE_RENDER = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // decoded item kind
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SPARK  = 2'd1;
  localparam logic [1:0] KIND_SHIFT  = 2'd2;
  localparam logic [1:0] KIND_RENDER = 2'd3;

  // register indexes
  localparam logic [1:0] REG_SPARK_LOW    = 2'd0;
  localparam logic [1:0] REG_SPARK_HIGH   = 2'd1;
  localparam logic [1:0] REG_COOLING_GAIN = 2'd2;
  localparam logic [1:0] REG_BOTTOM_HUE   = 2'd3;

  localparam logic [7:0] RST_SPARK_LOW    = 8'd64;
  localparam logic [7:0] RST_SPARK_HIGH   = 8'd255;
  localparam logic [7:0] RST_COOLING_GAIN = 8'd64;
  localparam logic [7:0] RST_BOTTOM_HUE   = 8'd25;

  localparam logic [31:0] COOL_K     = 32'd12800; // 256 * 50
  localparam int          CHAIN_BASE = 32;

  typedef struct packed {
    logic load;
    logic spk_go;
    logic spk_wr;
    logic sh_head;
    logic sh_wr;
    logic rd_a;
    logic rd_b;
    logic cap_b;
    logic mix;
    logic cool;
    logic vdiv_go;
    logic hdiv_go;
    logic hsv1;
    logic hsv2;
    logic emit;
  } lfh_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       div_done;
    logic       sweep_last;
    logic       out_free;
  } lfh_sts_t;

endpackage

`default_nettype wire

### rtl/core/lfh_div.sv
// lfh_div: 32-bit restoring divider, one quotient bit per cycle, remainder out
// depends on nothing; used by lfh_dp for the spark modulo
`default_nettype none

module lfh_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [31:0]      rem
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] quot_r, quot_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [32:0] sh;
  logic        ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    sh       = {rem_r, quot_r[31]};
    ge       = sh >= {1'b0, dsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quot_nxt = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? 32'(sh - {1'b0, dsr_r}) : sh[31:0];
      quot_nxt = {quot_r[30:0], ge};
      cnt_nxt  = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

### rtl/core/lfh_dp.sv
// lfh_dp: datapath with heat memory, spark row, render arithmetic and output register
// depends on lfh_pkg and lfh_div; driven by lfh_ctrl commands
`default_nettype none

module lfh_dp
  import lfh_pkg::*;
#(
  parameter int GRID_COLUMNS = 16,
  parameter int GRID_ROWS    = 8,
  parameter int PANEL_SIDE   = 8
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire lfh_cfg_t cfg,
  input  wire lfh_in_t  in_data,
  input  wire lfh_cmd_t cmd,
  output lfh_sts_t      sts,
  output logic          out_valid,
  input  wire logic     out_ready,
  output lfh_out_t      out_data
);

  localparam int CW    = $clog2(GRID_COLUMNS);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int AW    = CW + RW;
  localparam int DEPTH = 2 ** AW;
  localparam logic [31:0] POS_K = 32'(64 * (GRID_ROWS - 1));
  // ceil(2^24 / (GRID_ROWS-1)), exact floor division for operands below 2^13
  localparam logic [24:0] RECIP =
    25'(((64'd1 << 24) + 64'(GRID_ROWS - 2)) / 64'(GRID_ROWS - 1));

  lfh_in_t  item_r;
  logic [RW-1:0] head_r;
  logic [GRID_ROWS-1:0] valid_r;
  logic [CW-1:0] cnt_r;
  logic [7:0] spark_r [GRID_COLUMNS];
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;
  logic       rvld_r;
  logic [7:0] a_r, b_r, lo_r, val_r;
  logic [16:0] s_r;
  logic [10:0] gr_r, hr_r;
  logic [31:0] pos_r, neg_r;
  logic [13:0] vq_r;
  logic [7:0]  hue_r;
  logic [2:0]  sect_r;
  logic [16:0] mq_r, mt_r;
  logic [24:0] pq_r, pt_r;
  logic        out_valid_r;
  lfh_out_t    out_r;

  logic          col_ok, row_ok;
  logic [CW-1:0] col_i;
  logic [RW-1:0] row_i, phys_a, phys_b, head_dec, raddr_row;
  logic [7:0]    lo, hi, rd_val;
  logic          div_go, div_busy, div_done;
  logic [31:0]   div_dnd, div_dsr, rem;
  logic [31:0]   diff;
  logic [37:0]   vprod;
  logic [35:0]   hprod;
  logic [10:0]   h6;
  logic [7:0]    fr;
  logic [32:0]   cq_w, ct_w;
  logic [15:0]   cv_w;
  logic [23:0]   cp_w;
  logic [7:0]    cq, ct, cv, cp;
  logic [7:0]    rr, gg, bb;
  int            pq_i, mc_i, br_i, raw_i, col_int;
  logic [7:0]    idx;

  function automatic logic [RW-1:0] phys(input logic [RW-1:0] hd, input logic [RW-1:0] y);
    logic [RW:0] sum;
    sum = (RW+1)'(hd) + (RW+1)'(y);
    if (sum >= (RW+1)'(GRID_ROWS)) sum = sum - (RW+1)'(GRID_ROWS);
    return sum[RW-1:0];
  endfunction

  // item decode for the controller
  always_comb begin
    col_ok = 32'(in_data.column) < 32'(GRID_COLUMNS);
    row_ok = 32'(in_data.heat_row) < 32'(GRID_ROWS);
    case (in_data.mode)
      MODE_SPARK:  sts.kind = col_ok ? KIND_SPARK : KIND_NONE;
      MODE_SHIFT:  sts.kind = KIND_SHIFT;
      MODE_RENDER: sts.kind = (col_ok && row_ok) ? KIND_RENDER : KIND_NONE;
      default:     sts.kind = KIND_NONE;
    endcase
    sts.div_done   = div_done;
    sts.sweep_last = cnt_r == CW'(GRID_COLUMNS - 1);
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign col_i     = CW'(item_r.column);
  assign row_i     = RW'(item_r.heat_row);
  assign phys_a    = phys(head_r, row_i);
  assign phys_b    = phys(head_r, row_i - RW'(1));
  assign head_dec  = (head_r == '0) ? RW'(GRID_ROWS - 1) : head_r - RW'(1);
  assign raddr_row = cmd.rd_a ? phys_a : phys_b;
  assign rd_val    = rvld_r ? rdata_r : 8'd0;

  // out-of-order bounds are swapped
  assign lo = (cfg.spark_high < cfg.spark_low) ? cfg.spark_high : cfg.spark_low;
  assign hi = (cfg.spark_high < cfg.spark_low) ? cfg.spark_low : cfg.spark_high;

  // divider for the spark modulo
  assign div_go  = cmd.spk_go;
  assign div_dnd = item_r.random_word;
  assign div_dsr = 32'(9'(hi) - 9'(lo) + 9'd1);

  lfh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_dnd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (rem)
  );

  // divides by GRID_ROWS-1 as reciprocal multiplies; the 16384 factor is a shift
  assign diff  = (pos_r > neg_r) ? pos_r - neg_r : 32'd0;
  assign vprod = 38'(diff[26:14]) * 38'(RECIP);
  assign hprod = 36'(hr_r) * 36'(RECIP);

  // hsv channels and chain index
  always_comb begin
    h6   = 11'(hue_r) * 11'd6;
    fr   = h6[7:0];
    cv_w = {val_r, 8'd0} - 16'(val_r);
    cp_w = 24'(cv_w);
    cq_w = {pq_r, 8'd0} - 33'(pq_r);
    ct_w = {pt_r, 8'd0} - 33'(pt_r);
    cv   = cv_w[15:8];
    cp   = cp_w[23:16];
    cq   = cq_w[31:24];
    ct   = ct_w[31:24];
    case (sect_r)
      3'd0:    begin rr = cv; gg = ct; bb = cp; end
      3'd1:    begin rr = cq; gg = cv; bb = cp; end
      3'd2:    begin rr = cp; gg = cv; bb = ct; end
      3'd3:    begin rr = cp; gg = cq; bb = cv; end
      3'd4:    begin rr = ct; gg = cp; bb = cv; end
      default: begin rr = cv; gg = cp; bb = cq; end
    endcase
    // panel number by compares against multiples of the panel side
    col_int = int'(item_r.column);
    pq_i    = 0;
    for (int k = 1; k < 16; k++) begin
      if (col_int >= k * PANEL_SIDE) pq_i = k;
    end
    mc_i  = col_int - pq_i * PANEL_SIDE;
    br_i  = GRID_ROWS - 1 - int'(item_r.heat_row);
    raw_i = mc_i[0] ? PANEL_SIDE - 1 - br_i : br_i;
    idx   = 8'(CHAIN_BASE + pq_i * PANEL_SIDE * PANEL_SIDE + mc_i * PANEL_SIDE + raw_i);
  end

  // heat memory: one write port for the shift sweep, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.sh_wr) mem[{head_r, cnt_r}] <= spark_r[cnt_r];
    rdata_r <= mem[{raddr_row, col_i}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      valid_r     <= '0;
      cnt_r       <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < GRID_COLUMNS; c++) spark_r[c] <= 8'd0;
    end else begin
      rvld_r <= valid_r[raddr_row];
      if (cmd.sh_head) begin
        head_r            <= head_dec;
        valid_r[head_dec] <= 1'b1;
        cnt_r             <= '0;
      end else if (cmd.sh_wr) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.spk_wr) spark_r[col_i] <= lo_r + rem[7:0];
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.spk_go) lo_r <= lo;
    if (cmd.rd_b) a_r <= rd_val;
    if (cmd.cap_b) b_r <= (row_i == '0) ? spark_r[col_i] : rd_val;
    if (cmd.mix) begin
      s_r  <= 17'(9'd256 - 9'(item_r.blend_phase)) * 17'(a_r)
            + 17'(item_r.blend_phase) * 17'(b_r);
      gr_r <= 11'(cfg.cooling_gain) * 11'(item_r.heat_row);
      hr_r <= 11'(cfg.bottom_hue) * 11'(item_r.heat_row);
    end
    if (cmd.cool) begin
      pos_r <= 32'(s_r) * POS_K;
      neg_r <= 32'(gr_r) * COOL_K;
    end
    if (cmd.vdiv_go) vq_r <= vprod[37:24];
    if (cmd.hdiv_go) begin
      val_r <= (vq_r > 14'd255) ? 8'd255 : vq_r[7:0];
      hue_r <= hprod[31:24];
    end
    if (cmd.hsv1) begin
      sect_r <= h6[10:8];
      mq_r   <= 17'(32'd65536 - 32'd255 * 32'(fr));
      mt_r   <= 17'(32'd65536 - 32'd255 * (32'd256 - 32'(fr)));
    end
    if (cmd.hsv2) begin
      pq_r <= 25'(val_r) * 25'(mq_r);
      pt_r <= 25'(val_r) * 25'(mt_r);
    end
    if (cmd.emit) begin
      out_r.led_index <= idx;
      out_r.red       <= rr;
      out_r.green     <= gg;
      out_r.blue      <= bb;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_go |-> !div_busy) else $error("divider started while busy");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready)) else $error("result overwritten");
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sh_head |=> valid_r[head_r]) else $error("new head row not marked");

endmodule

`default_nettype wire

### rtl/core/lfh_ctrl.sv
// lfh_ctrl: state machine sequencing spark, shift and render items
// depends on lfh_pkg; issues lfh_cmd_t to lfh_dp and reads lfh_sts_t back
`default_nettype none

module lfh_ctrl
  import lfh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire lfh_sts_t sts,
  output lfh_cmd_t      cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SPK_GO  = 5'd1;
  localparam logic [4:0] S_SPK_W   = 5'd2;
  localparam logic [4:0] S_SH_HEAD = 5'd3;
  localparam logic [4:0] S_SH_WR   = 5'd4;
  localparam logic [4:0] S_RD_A    = 5'd5;
  localparam logic [4:0] S_RD_B    = 5'd6;
  localparam logic [4:0] S_RD_C    = 5'd7;
  localparam logic [4:0] S_MIX     = 5'd8;
  localparam logic [4:0] S_COOL    = 5'd9;
  localparam logic [4:0] S_VDIV    = 5'd10;
  localparam logic [4:0] S_HDIV    = 5'd12;
  localparam logic [4:0] S_HSV1    = 5'd14;
  localparam logic [4:0] S_HSV2    = 5'd15;
  localparam logic [4:0] S_EMIT    = 5'd16;

  logic [4:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = state_r == S_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (sts.kind)
            KIND_SPARK:  state_nxt = S_SPK_GO;
            KIND_SHIFT:  state_nxt = S_SH_HEAD;
            KIND_RENDER: state_nxt = S_RD_A;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_SPK_GO: begin
        cmd.spk_go = 1'b1;
        state_nxt  = S_SPK_W;
      end
      S_SPK_W: begin
        if (sts.div_done) begin
          cmd.spk_wr = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SH_HEAD: begin
        cmd.sh_head = 1'b1;
        state_nxt   = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.sh_wr = 1'b1;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_RD_A: begin
        cmd.rd_a  = 1'b1;
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        cmd.rd_b  = 1'b1;
        state_nxt = S_RD_C;
      end
      S_RD_C: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = S_COOL;
      end
      S_COOL: begin
        cmd.cool  = 1'b1;
        state_nxt = S_VDIV;
      end
      S_VDIV: begin
        cmd.vdiv_go = 1'b1;
        state_nxt   = S_HDIV;
      end
      S_HDIV: begin
        cmd.hdiv_go = 1'b1;
        state_nxt   = S_HSV1;
      end
      S_HSV1: begin
        cmd.hsv1  = 1'b1;
        state_nxt = S_HSV2;
      end
      S_HSV2: begin
        cmd.hsv2  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register can take the beat
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/led_fire_heat_grid_renderer.sv
// led_fire_heat_grid_renderer: top level with the register port
// depends on lfh_pkg, lfh_ctrl, lfh_dp (and lfh_div inside it)
`default_nettype none

// One item is taken at a time. A spark item waits on the 32-step divider that
// forms the random modulo. In a shift item the spark row is swept into the
// heat memory one column a cycle while a ring pointer moves the rows. A render
// item makes two reads of the heat memory port, forms the blend and cooling
// terms, runs the reciprocal multiplies for the divides by GRID_ROWS-1 (cooled
// value, row hue) and then the hsv multiplies. Items that change nothing are
// dropped in the idle state. The finished beat sits in an output register, so
// the next item is accepted while it waits; a render item only stalls while
// that register still holds an unaccepted beat. Rows never written since reset
// read as zero.

module led_fire_heat_grid_renderer
  import lfh_pkg::*;
#(
  parameter int GRID_COLUMNS = 16,
  parameter int GRID_ROWS    = 8,
  parameter int PANEL_SIDE   = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire lfh_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output lfh_out_t         out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  lfh_cfg_t cfg_r, cfg_nxt;
  lfh_cmd_t cmd;
  lfh_sts_t sts;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt    = cfg_r;
    cfg_prdata = '0;
    case (cfg_paddr[3:2])
      REG_SPARK_LOW: begin
        cfg_prdata = 32'(cfg_r.spark_low);
        if (wr_en) cfg_nxt.spark_low = cfg_pwdata[7:0];
      end
      REG_SPARK_HIGH: begin
        cfg_prdata = 32'(cfg_r.spark_high);
        if (wr_en) cfg_nxt.spark_high = cfg_pwdata[7:0];
      end
      REG_COOLING_GAIN: begin
        cfg_prdata = 32'(cfg_r.cooling_gain);
        if (wr_en) cfg_nxt.cooling_gain = cfg_pwdata[7:0];
      end
      REG_BOTTOM_HUE: begin
        cfg_prdata = 32'(cfg_r.bottom_hue);
        if (wr_en) cfg_nxt.bottom_hue = cfg_pwdata[7:0];
      end
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spark_low    <= RST_SPARK_LOW;
      cfg_r.spark_high   <= RST_SPARK_HIGH;
      cfg_r.cooling_gain <= RST_COOLING_GAIN;
      cfg_r.bottom_hue   <= RST_BOTTOM_HUE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lfh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfh_dp #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .PANEL_SIDE   (PANEL_SIDE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
